// File: design/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame decoder.
// No dependencies; imported by the parser, the output buffer and the top level.
`timescale 1ns / 1ps
`default_nettype none

package wsfd_pkg;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [1:0] CLS_MSG  = 2'd0;
    localparam logic [1:0] CLS_PING = 2'd1;
    localparam logic [1:0] CLS_PONG = 2'd2;
    localparam logic [1:0] CLS_DROP = 2'd3;

    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_LEN64 = 2'd2;
    localparam logic [1:0] ST_BIG   = 2'd3;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    typedef struct packed {
        logic [15:0] frame_length;
        logic [1:0]  status;
        logic [1:0]  event_class;
        logic        last;
        logic        final_fragment;
        logic [3:0]  frame_opcode;
        logic [7:0]  payload_byte;
    } result_t;

    function automatic logic [1:0] class_of(input logic [3:0] op);
        logic [1:0] cls;
        unique case (op)
            OP_CONT, OP_TEXT: cls = CLS_MSG;
            OP_PING:          cls = CLS_PING;
            OP_PONG:          cls = CLS_PONG;
            default:          cls = CLS_DROP;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

// File: design/websocket_frame_decoder.sv
// Top level of the WebSocket frame decoder: stream ports, size limit register.
// Depends on wsfd_pkg, wsfd_parser and wsfd_out_buf.
`timescale 1ns / 1ps
`default_nettype none

// Decodes a received WebSocket byte stream (16-bit lengths at most): header,
// optional extended length and mask key are absorbed, each payload byte comes
// out unmasked with opcode, FIN, event class and frame length; empty frames,
// 64-bit length codes and oversize frames give one status item each. One byte
// is taken per clock while s_tready is high; the parser updates its state and
// the result is written into a two-entry output buffer at the same edge, so
// s_tready drops only while both buffer entries wait on m_tready.
module websocket_frame_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,   // size limit
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] data_byte
    input  wire logic        s_tuser,       // [0] segment_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,       // [7:0] payload_byte, [11:8] frame_opcode,
                                            // [12] final_fragment, [28:13] frame_length
    output logic [3:0]       m_tuser,       // [1:0] event_class, [3:2] status
    output logic             m_tlast        // last
);
    import wsfd_pkg::*;

    logic [15:0] size_limit_reg;
    logic        in_accept;
    logic        res_valid;
    result_t     res;
    result_t     out_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_limit_reg <= 16'h0000;
        end else if (cfg_wr_en) begin
            size_limit_reg <= cfg_wr_data;
        end
    end

    assign in_accept = s_tvalid & s_tready;

    wsfd_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_accept     (in_accept),
        .data_byte     (s_tdata),
        .segment_start (s_tuser),
        .size_limit    (size_limit_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    wsfd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .can_take  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {3'b000, out_res.frame_length, out_res.final_fragment,
                      out_res.frame_opcode, out_res.payload_byte};
    assign m_tuser = {out_res.status, out_res.event_class};
    assign m_tlast = out_res.last;

endmodule

`default_nettype wire

// File: design/wsfd_parser.sv
// Header, length, mask key and payload parser: one byte per accepted item.
// Depends on wsfd_pkg for the result struct, status and class codes.
`timescale 1ns / 1ps
`default_nettype none

module wsfd_parser (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_accept,
    input  wire logic [7:0]       data_byte,
    input  wire logic             segment_start,
    input  wire logic [15:0]      size_limit,
    output logic                  res_valid,
    output wsfd_pkg::result_t     res
);
    import wsfd_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR1   = 3'd0,
        PH_HDR2   = 3'd1,
        PH_EXT_HI = 3'd2,
        PH_EXT_LO = 3'd3,
        PH_KEY    = 3'd4,
        PH_DATA   = 3'd5,
        PH_DROP   = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next, cur_phase;
    logic [3:0]  held_opcode_reg, held_opcode_next;
    logic        held_fin_reg, held_fin_next;
    logic        masked_reg, masked_next;
    logic [15:0] payload_length_reg, payload_length_next;
    logic [15:0] byte_index_reg, byte_index_next;
    logic [31:0] mask_key_reg, mask_key_next;

    logic        len_known;
    logic [15:0] len_cand;
    logic [15:0] idx_inc;
    logic [7:0]  key_byte;

    assign cur_phase = segment_start ? PH_HDR1 : phase_reg;
    assign idx_inc   = byte_index_reg + 16'd1;

    always_comb begin
        unique case (byte_index_reg[1:0])
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next          = cur_phase;
        held_opcode_next    = held_opcode_reg;
        held_fin_next       = held_fin_reg;
        masked_next         = masked_reg;
        payload_length_next = payload_length_reg;
        byte_index_next     = byte_index_reg;
        mask_key_next       = mask_key_reg;
        len_known           = 1'b0;
        len_cand            = {8'h00, data_byte};

        res_valid          = 1'b0;
        res.payload_byte   = 8'h00;
        res.frame_opcode   = held_opcode_reg;
        res.final_fragment = held_fin_reg;
        res.event_class    = class_of(held_opcode_reg);
        res.frame_length   = 16'h0000;
        res.last           = 1'b1;
        res.status         = ST_EMPTY;

        unique case (cur_phase)
            PH_HDR2: begin
                masked_next = data_byte[7];
                if (data_byte[6:0] == LEN7_EXT64) begin
                    payload_length_next = 16'h0000;
                    res_valid           = 1'b1;
                    res.status          = ST_LEN64;
                    phase_next          = PH_DROP;
                end else if (data_byte[6:0] == LEN7_EXT16) begin
                    payload_length_next = 16'h0000;
                    phase_next          = PH_EXT_HI;
                end else begin
                    len_cand  = {9'h000, data_byte[6:0]};
                    len_known = 1'b1;
                end
            end
            PH_EXT_HI: begin
                payload_length_next = {data_byte, 8'h00};
                phase_next          = PH_EXT_LO;
            end
            PH_EXT_LO: begin
                len_cand  = {payload_length_reg[15:8], data_byte};
                len_known = 1'b1;
            end
            PH_KEY: begin
                mask_key_next = {mask_key_reg[23:0], data_byte};
                if (idx_inc < 16'd4) begin
                    byte_index_next = idx_inc;
                end else begin
                    byte_index_next = 16'h0000;
                    if (payload_length_reg == 16'h0000) begin
                        res_valid  = 1'b1;
                        phase_next = PH_HDR1;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                byte_index_next  = idx_inc;
                res_valid        = 1'b1;
                res.payload_byte = data_byte ^ (masked_reg ? key_byte : 8'h00);
                res.frame_length = payload_length_reg;
                res.last         = (idx_inc >= payload_length_reg);
                res.status       = ST_BYTE;
                if (idx_inc >= payload_length_reg) phase_next = PH_HDR1;
            end
            PH_DROP: begin
                phase_next = PH_DROP;
            end
            default: begin
                held_fin_next    = data_byte[7];
                held_opcode_next = data_byte[3:0];
                phase_next       = PH_HDR2;
            end
        endcase

        if (len_known) begin
            payload_length_next = len_cand;
            if ((size_limit != 16'h0000) && (len_cand > size_limit)) begin
                res_valid        = 1'b1;
                res.frame_length = len_cand;
                res.status       = ST_BIG;
                phase_next       = PH_DROP;
            end else begin
                byte_index_next = 16'h0000;
                if (masked_next) begin
                    mask_key_next = 32'h0000_0000;
                    phase_next    = PH_KEY;
                end else if (len_cand == 16'h0000) begin
                    res_valid  = 1'b1;
                    phase_next = PH_HDR1;
                end else begin
                    phase_next = PH_DATA;
                end
            end
        end

        if (!in_accept) res_valid = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_HDR1;
            held_opcode_reg    <= 4'h0;
            held_fin_reg       <= 1'b0;
            masked_reg         <= 1'b0;
            payload_length_reg <= 16'h0000;
            byte_index_reg     <= 16'h0000;
            mask_key_reg       <= 32'h0000_0000;
        end else if (in_accept) begin
            phase_reg          <= phase_next;
            held_opcode_reg    <= held_opcode_next;
            held_fin_reg       <= held_fin_next;
            masked_reg         <= masked_next;
            payload_length_reg <= payload_length_next;
            byte_index_reg     <= byte_index_next;
            mask_key_reg       <= mask_key_next;
        end
    end

endmodule

`default_nettype wire

// File: design/wsfd_out_buf.sv
// Two-entry result register with skid stage between the parser and m_ side.
// Depends on wsfd_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module wsfd_out_buf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire wsfd_pkg::result_t push_data,
    output logic                   can_take,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output wsfd_pkg::result_t      out_data
);
    import wsfd_pkg::*;

    logic    main_valid_reg, skid_valid_reg;
    result_t main_reg, skid_reg;
    logic    pop;

    assign pop       = main_valid_reg & out_ready;
    assign can_take  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                main_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                main_reg       <= push_data;
                main_valid_reg <= push;
            end
        end else if (push) begin
            if (!main_valid_reg) begin
                main_reg       <= push_data;
                main_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= push_data;
                skid_valid_reg <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: dv/tb_websocket_frame_decoder.sv
// Self-checking testbench for websocket_frame_decoder: sends frame bytes, predicts each item.
// Depends on wsfd_pkg and the RTL under design/; needs no other files.
`timescale 1ns / 1ps

module tb_websocket_frame_decoder;
    import wsfd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER1, PH_HEADER2, PH_LEN_HI, PH_LEN_LO, PH_KEY, PH_DATA, PH_DROP
    } parse_phase_t;

    typedef enum logic [1:0] {FORM_SHORT, FORM_EXT16, FORM_EXT64} frame_form_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    // decoder state as the byte stream leaves it
    parse_phase_t rx_phase = PH_HEADER1;
    logic [3:0]   rx_opcode = 4'h0;
    logic         rx_fin = 1'b0;
    logic         rx_masked = 1'b0;
    logic [15:0]  rx_length = 16'h0;
    logic [15:0]  rx_index = 16'h0;
    logic [31:0]  rx_key = 32'h0;
    logic [15:0]  limit_reg = 16'h0;

    result_t      expected_results[$];
    logic [7:0]   frame_bytes[$];
    int unsigned  mismatch_count = 0;
    int unsigned  counted_items = 0;
    bit           src_idle_en = 1'b1;
    bit           sink_idle_en = 1'b1;
    bit           need_restart = 1'b0;

    always #5 aclk = ~aclk;

    websocket_frame_decoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    function automatic logic [1:0] class_for(input logic [3:0] op);
        if (op == OP_CONT || op == OP_TEXT) return CLS_MSG;
        if (op == OP_PING) return CLS_PING;
        if (op == OP_PONG) return CLS_PONG;
        return CLS_DROP;
    endfunction

    task automatic expect_result(input logic [7:0] pb, input logic [15:0] len,
                                 input logic lst, input logic [1:0] st);
        result_t r;
        r.payload_byte   = pb;
        r.frame_opcode   = rx_opcode;
        r.final_fragment = rx_fin;
        r.event_class    = class_for(rx_opcode);
        r.frame_length   = len;
        r.last           = lst;
        r.status         = st;
        expected_results.push_back(r);
    endtask

    task automatic finish_length();
        if (limit_reg != 16'h0 && rx_length > limit_reg) begin
            expect_result(8'h00, rx_length, 1'b1, ST_BIG);
            rx_phase = PH_DROP;
        end else begin
            rx_index = 16'h0;
            if (rx_masked) begin
                rx_key = 32'h0;
                rx_phase = PH_KEY;
            end else if (rx_length == 16'h0) begin
                expect_result(8'h00, 16'h0, 1'b1, ST_EMPTY);
                rx_phase = PH_HEADER1;
            end else begin
                rx_phase = PH_DATA;
            end
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic seg);
        logic [7:0] k;
        logic       done;
        int         sh;
        if (seg) rx_phase = PH_HEADER1;
        if (rx_phase != PH_DROP) counted_items++;
        case (rx_phase)
            PH_HEADER2: begin
                rx_masked = b[7];
                if (b[6:0] == LEN7_EXT64) begin
                    rx_length = 16'h0;
                    expect_result(8'h00, 16'h0, 1'b1, ST_LEN64);
                    rx_phase = PH_DROP;
                end else if (b[6:0] == LEN7_EXT16) begin
                    rx_length = 16'h0;
                    rx_phase = PH_LEN_HI;
                end else begin
                    rx_length = {9'd0, b[6:0]};
                    finish_length();
                end
            end
            PH_LEN_HI: begin
                rx_length = {b, 8'h00};
                rx_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                rx_length[7:0] = b;
                finish_length();
            end
            PH_KEY: begin
                rx_key = {rx_key[23:0], b};
                rx_index++;
                if (rx_index == 16'd4) begin
                    rx_index = 16'h0;
                    if (rx_length == 16'h0) begin
                        expect_result(8'h00, 16'h0, 1'b1, ST_EMPTY);
                        rx_phase = PH_HEADER1;
                    end else begin
                        rx_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                sh = 24 - 8 * int'(rx_index[1:0]);
                k = rx_masked ? 8'(rx_key >> sh) : 8'h00;
                rx_index++;
                done = (rx_index >= rx_length);
                expect_result(b ^ k, rx_length, done, ST_BYTE);
                if (done) rx_phase = PH_HEADER1;
            end
            PH_DROP: ;
            default: begin
                rx_fin = b[7];
                rx_opcode = b[3:0];
                rx_phase = PH_HEADER2;
            end
        endcase
    endtask

    task automatic send_item(input logic [7:0] b, input logic seg);
        if (src_idle_en) begin
            while ($urandom_range(99) < 30) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= seg;
        do @(posedge aclk); while (!s_tready);
        absorb_byte(b, seg);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        limit_reg = value;
    endtask

    function automatic logic [3:0] pick_opcode();
        case ($urandom_range(5))
            0: return OP_CONT;
            1: return OP_TEXT;
            2: return OP_PING;
            3: return OP_PONG;
            default: return 4'($urandom());
        endcase
    endfunction

    task automatic build_frame(input logic [3:0] op, input logic msk,
                               input int unsigned plen, input frame_form_t form);
        logic [31:0] key;
        int unsigned body;
        key = $urandom();
        frame_bytes.delete();
        frame_bytes.push_back({1'($urandom_range(1)), 3'($urandom_range(7)), op});
        case (form)
            FORM_EXT64: begin
                frame_bytes.push_back({msk, LEN7_EXT64});
                repeat ($urandom_range(6)) frame_bytes.push_back(8'($urandom()));
                need_restart = 1'b1;
            end
            FORM_EXT16: begin
                frame_bytes.push_back({msk, LEN7_EXT16});
                frame_bytes.push_back(8'(plen >> 8));
                frame_bytes.push_back(8'(plen));
            end
            default: begin
                frame_bytes.push_back({msk, 7'(plen)});
            end
        endcase
        if (form != FORM_EXT64) begin
            body = plen;
            // cut the body of an oversize frame to at most four bytes
            if (limit_reg != 16'h0 && plen > limit_reg) begin
                body = $urandom_range(4);
                need_restart = 1'b1;
            end
            if (msk) begin
                for (int i = 0; i < 4; i++) frame_bytes.push_back(key[31 - 8 * i -: 8]);
            end
            repeat (body) frame_bytes.push_back(8'($urandom()));
        end
    endtask

    task automatic send_frame(input logic [3:0] op, input logic msk, input int unsigned plen,
                              input frame_form_t form, input bit truncate);
        logic        first_seg;
        int unsigned count;
        first_seg = need_restart | 1'($urandom_range(1));
        need_restart = 1'b0;
        build_frame(op, msk, plen, form);
        count = frame_bytes.size();
        if (truncate && count > 1) begin
            count = $urandom_range(1, count - 1);
            need_restart = 1'b1;
        end
        for (int i = 0; i < count; i++) send_item(frame_bytes[i], (i == 0) ? first_seg : 1'b0);
    endtask

    task automatic pick_shape(output int unsigned plen, output frame_form_t form);
        int unsigned r;
        r = $urandom_range(99);
        form = FORM_SHORT;
        if (r < 40) begin
            plen = $urandom_range(8);
        end else if (r < 65) begin
            plen = $urandom_range(9, 125);
        end else if (r < 80) begin
            form = FORM_EXT16;
            plen = $urandom_range(300);
        end else if (r < 88) begin
            if (limit_reg != 16'h0 && limit_reg < 16'd700) plen = limit_reg + $urandom_range(1);
            else plen = $urandom_range(16);
            if ($urandom_range(1)) form = FORM_EXT16;
        end else if (r < 95) begin
            form = FORM_EXT16;
            plen = $urandom_range(65535);
            if (!(limit_reg != 16'h0 && plen > limit_reg)) plen = $urandom_range(126, 700);
        end else begin
            form = FORM_EXT64;
            plen = 0;
        end
        if (form == FORM_SHORT && plen > 125) form = FORM_EXT16;
    endtask

    task automatic run_random_frames(input int unsigned n);
        int unsigned stop_at;
        int unsigned plen;
        int unsigned r;
        frame_form_t form;
        stop_at = counted_items + n;
        while (counted_items < stop_at) begin
            r = $urandom_range(99);
            pick_shape(plen, form);
            if (r < 80) begin
                send_frame(pick_opcode(), 1'($urandom_range(1)), plen, form, 1'b0);
            end else if (r < 92) begin
                send_frame(pick_opcode(), 1'($urandom_range(1)), plen, form, 1'b1);
            end else begin
                repeat ($urandom_range(1, 6)) send_item(8'($urandom()), 1'($urandom_range(1)));
                need_restart = 1'b1;
            end
        end
    endtask

    task automatic test_empty_frames();
        send_frame(OP_TEXT, 1'b0, 0, FORM_SHORT, 1'b0);
        send_frame(OP_PING, 1'b1, 0, FORM_SHORT, 1'b0);
        send_frame(OP_CONT, 1'b0, 0, FORM_EXT16, 1'b0);
    endtask

    task automatic test_length_codes();
        send_frame(4'h2, 1'b0, 0, FORM_EXT64, 1'b0);
        send_frame(OP_PONG, 1'b1, 3, FORM_EXT16, 1'b0);
        send_frame(4'hF, 1'b0, 2, FORM_SHORT, 1'b0);
    endtask

    task automatic test_oversize();
        write_limit(16'd1);
        send_frame(OP_TEXT, 1'b1, 2, FORM_SHORT, 1'b0);
        send_frame(OP_TEXT, 1'b1, 1, FORM_SHORT, 1'b0);
        write_limit(16'hFFFE);
        send_frame(OP_PING, 1'b0, 65535, FORM_EXT16, 1'b0);
        write_limit(16'hFFFF);
        send_frame(OP_PONG, 1'b0, 125, FORM_SHORT, 1'b0);
    endtask

    task automatic test_limit_sweep();
        logic [15:0] limits[7];
        limits = '{16'd0, 16'hFFFF, 16'd1, 16'd125, 16'd126,
                   16'($urandom_range(2, 700)), 16'($urandom())};
        foreach (limits[i]) begin
            write_limit(limits[i]);
            run_random_frames(130);
        end
    endtask

    task automatic test_back_to_back();
        write_limit(16'd0);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        run_random_frames(250);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    task automatic test_random_traffic();
        write_limit(16'($urandom_range(1, 400)));
        run_random_frames(300);
        write_limit(16'd0);
        run_random_frames(250);
    endtask

    always @(posedge aclk) begin
        m_tready <= sink_idle_en ? ($urandom_range(99) >= 30) : 1'b1;
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] seen);
        if (want !== seen) begin
            $error("%s: expected %0d, actual %0d", name, want, seen);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected item: status %0d payload_byte %0d", m_tuser[3:2], m_tdata[7:0]);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("payload_byte", 16'(want.payload_byte), 16'(m_tdata[7:0]));
                check_field("frame_opcode", 16'(want.frame_opcode), 16'(m_tdata[11:8]));
                check_field("final_fragment", 16'(want.final_fragment), 16'(m_tdata[12]));
                check_field("frame_length", want.frame_length, m_tdata[28:13]);
                check_field("event_class", 16'(want.event_class), 16'(m_tuser[1:0]));
                check_field("status", 16'(want.status), 16'(m_tuser[3:2]));
                check_field("last", 16'(want.last), 16'(m_tlast));
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_frames();
        test_length_codes();
        test_oversize();
        test_limit_sweep();
        test_back_to_back();
        test_random_traffic();
        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
design/wsfd_pkg.sv
design/wsfd_parser.sv
design/wsfd_out_buf.sv
design/websocket_frame_decoder.sv
dv/tb_websocket_frame_decoder.sv
